// ===== design/ebwr_pkg.sv =====
// Shared types, Q30 constants and rounding helpers for the body-to-world rate rotator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ebwr_pkg;

    // Signed Q30 value in [-1.0, 1.0] and a little beyond for reduced angles.
    typedef logic signed [31:0] q30_t;
    // Positive Q30 value below 1.0 (squares and Horner products).
    typedef logic [29:0] qpos_t;
    // Positive Q30 value up to and including 1.0 (Horner terms).
    typedef logic [30:0] qone_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } trig_t;

    localparam int FRAC = 30;
    localparam int ANGLE_SHIFT = 17;
    localparam int HORNER_STEPS = 4;

    localparam qone_t Q_ONE = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
    localparam logic [29:0] QUARTER_PI_Q = 30'd843314856;
    localparam logic [63:0] HALF_LSB = 64'd536870912;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Exact truncating division of a 30-bit value by d: (x * M) >> S, with
    // S = 30 + ceil(log2 d) and M = ceil(2^S / d).
    localparam int unsigned SIN_SH [HORNER_STEPS] = '{37, 36, 35, 33};
    localparam logic [63:0] SIN_M [HORNER_STEPS] = '{
        ((64'd1 << 37) + 64'd71) / 64'd72,
        ((64'd1 << 36) + 64'd41) / 64'd42,
        ((64'd1 << 35) + 64'd19) / 64'd20,
        ((64'd1 << 33) + 64'd5) / 64'd6
    };
    localparam int unsigned COS_SH [HORNER_STEPS] = '{37, 36, 35, 34};
    localparam logic [63:0] COS_M [HORNER_STEPS] = '{
        ((64'd1 << 37) + 64'd89) / 64'd90,
        ((64'd1 << 36) + 64'd55) / 64'd56,
        ((64'd1 << 35) + 64'd29) / 64'd30,
        ((64'd1 << 34) + 64'd11) / 64'd12
    };

    // Q60 product to Q30, nearest, ties away from zero.
    function automatic logic signed [33:0] qround(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [33:0] m;
        mag = p[63] ? 64'(-p) : 64'(p);
        m = 34'((mag + HALF_LSB) >> FRAC);
        return p[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [33:0] w;
        w = qround(64'(a) * 64'(b));
        return w[31:0];
    endfunction

    function automatic qpos_t qmul_pos(input qpos_t a, input qone_t b);
        logic [60:0] p;
        p = 61'(a) * 61'(b);
        return 30'((p + 61'(HALF_LSB)) >> FRAC);
    endfunction

endpackage

// ===== design/ebwr_reduce.sv =====
// Quarter-turn angle reduction: restoring division by pi/2, one quotient bit per stage.
// Depends on ebwr_pkg.
`timescale 1ns / 1ps

module ebwr_reduce #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output ebwr_pkg::q30_t                r,
    output logic [1:0]                    quad
);
    import ebwr_pkg::*;

    localparam int XW = ANGLE_WIDTH + ANGLE_SHIFT;
    localparam int DW = ANGLE_WIDTH + 20;
    localparam int KW = ANGLE_WIDTH - 10;

    logic [XW-1:0] x;
    logic [XW-1:0] mag;
    logic [DW-1:0] rem_reg [KW+1];
    logic [KW-1:0] k_reg [KW+1];
    logic          neg_reg [KW+1];
    q30_t          r_reg;
    logic [1:0]    quad_reg;
    q30_t          diff;

    assign x   = {angle, {ANGLE_SHIFT{1'b0}}};
    assign mag = x[XW-1] ? XW'(-x) : x;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(mag) + DW'(QUARTER_PI_Q);
            k_reg[0]   <= '0;
            neg_reg[0] <= x[XW-1];
        end
    end

    for (genvar i = 1; i <= KW; i++) begin : g_div
        localparam logic [DW-1:0] DIVS = DW'(HALF_PI_Q) << (KW - i);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[i-1] >= DIVS) begin
                    rem_reg[i] <= rem_reg[i-1] - DIVS;
                    k_reg[i]   <= k_reg[i-1] | (KW'(1) << (KW - i));
                end else begin
                    rem_reg[i] <= rem_reg[i-1];
                    k_reg[i]   <= k_reg[i-1];
                end
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // The remainder still carries the pi/4 offset that centered the split.
    assign diff = $signed({1'b0, rem_reg[KW][30:0]}) - $signed(32'(QUARTER_PI_Q));

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= neg_reg[KW] ? -diff : diff;
            quad_reg <= neg_reg[KW] ? 2'(~k_reg[KW][1:0] + 2'd1) : k_reg[KW][1:0];
        end
    end

    assign r    = r_reg;
    assign quad = quad_reg;

endmodule

// ===== design/ebwr_sincos.sv =====
// Sine and cosine of a reduced angle by Horner evaluation, three stages per term,
// then quadrant selection. Depends on ebwr_pkg.
`timescale 1ns / 1ps

module ebwr_sincos (
    input  logic            aclk,
    input  logic            en,
    input  ebwr_pkg::q30_t  r,
    input  logic [1:0]      quad,
    output ebwr_pkg::trig_t trig
);
    import ebwr_pkg::*;

    typedef struct packed {
        q30_t       r;
        qpos_t      t2;
        logic [1:0] quad;
    } sc_pipe_t;

    localparam int PIPE_LEN = 3 * HORNER_STEPS + 3;

    sc_pipe_t    pipe_reg [PIPE_LEN];
    qpos_t       p_reg [2][HORNER_STEPS];
    logic [61:0] d_reg [2][HORNER_STEPS];
    qone_t       tt_reg [2][HORNER_STEPS];
    q30_t        s_raw_reg;
    qpos_t       cp_reg;
    q30_t        s_d_reg;
    qone_t       c_reg;
    trig_t       trig_reg;
    logic signed [33:0] sq;
    q30_t        s_fin;
    q30_t        c_fin;

    assign sq = qround(64'(r) * 64'(r));

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= '{r: r, t2: sq[29:0], quad: quad};
        end
    end

    for (genvar i = 1; i < PIPE_LEN; i++) begin : g_pipe
        always_ff @(posedge aclk) begin
            if (en) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    // Chain 0 is the sine series, chain 1 the cosine series.
    for (genvar c = 0; c < 2; c++) begin : g_chain
        for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
            localparam logic [31:0] MUL = (c == 0) ? SIN_M[j][31:0] : COS_M[j][31:0];
            localparam int unsigned SH = (c == 0) ? SIN_SH[j] : COS_SH[j];
            if (j == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (en) begin
                        p_reg[c][j] <= pipe_reg[0].t2;
                    end
                end
            end else begin : g_next
                always_ff @(posedge aclk) begin
                    if (en) begin
                        p_reg[c][j] <= qmul_pos(pipe_reg[3*j].t2, tt_reg[c][j-1]);
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[c][j]  <= 62'(p_reg[c][j]) * 62'(MUL);
                    tt_reg[c][j] <= Q_ONE - 31'(d_reg[c][j] >> SH);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_raw_reg <= qmul(pipe_reg[3*HORNER_STEPS].r,
                              $signed({1'b0, tt_reg[0][HORNER_STEPS-1]}));
            cp_reg    <= qmul_pos(pipe_reg[3*HORNER_STEPS].t2, tt_reg[1][HORNER_STEPS-1]);
            s_d_reg   <= s_raw_reg;
            c_reg     <= Q_ONE - 31'(cp_reg >> 1);
        end
    end

    assign s_fin = s_d_reg;
    assign c_fin = $signed({1'b0, c_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            case (pipe_reg[PIPE_LEN-1].quad)
                QUAD_0:  trig_reg <= '{s: s_fin, c: c_fin};
                QUAD_1:  trig_reg <= '{s: c_fin, c: -s_fin};
                QUAD_2:  trig_reg <= '{s: -s_fin, c: -c_fin};
                QUAD_3:  trig_reg <= '{s: -c_fin, c: s_fin};
                default: trig_reg <= '{s: s_fin, c: c_fin};
            endcase
        end
    end

    assign trig = trig_reg;

endmodule

// ===== design/ebwr_rotate.sv =====
// Rotation matrix build (two product stages, one add stage) and matrix-vector
// product with rounding and saturation. Depends on ebwr_pkg.
`timescale 1ns / 1ps

module ebwr_rotate #(
    parameter int RATE_WIDTH = 24
) (
    input  logic                         aclk,
    input  logic                         en,
    input  ebwr_pkg::trig_t              roll,
    input  ebwr_pkg::trig_t              pitch,
    input  ebwr_pkg::trig_t              yaw,
    input  logic signed [RATE_WIDTH-1:0] wx,
    input  logic signed [RATE_WIDTH-1:0] wy,
    input  logic signed [RATE_WIDTH-1:0] wz,
    output logic signed [RATE_WIDTH-1:0] world_x,
    output logic signed [RATE_WIDTH-1:0] world_y,
    output logic signed [RATE_WIDTH-1:0] world_z
);
    import ebwr_pkg::*;

    localparam int RE = 33;
    localparam int PW = RE + RATE_WIDTH;
    localparam int SW = PW + 2;
    localparam logic [SW-1:0] POS_LIM = SW'((64'd1 << (RATE_WIDTH - 1)) - 64'd1);
    localparam logic [SW-1:0] NEG_LIM = SW'(64'd1 << (RATE_WIDTH - 1));
    localparam logic [SW-1:0] RND = SW'(HALF_LSB);

    // Stage A
    q30_t spsr_reg, spcr_reg, cycp_reg, sycp_reg, cpsr_reg, cpcr_reg;
    q30_t sycr_reg, sysr_reg, cycr_reg, cysr_reg, cy_a_reg, sy_a_reg, sp_a_reg;
    // Stage B
    q30_t cyspsr_reg, cyspcr_reg, syspsr_reg, syspcr_reg;
    q30_t sycr_b_reg, sysr_b_reg, cycr_b_reg, cysr_b_reg;
    q30_t cycp_b_reg, sycp_b_reg, cpsr_b_reg, cpcr_b_reg, sp_b_reg;
    // Stage C
    logic signed [RE-1:0] m_reg [3][3];
    // Stage D, E, F
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [RATE_WIDTH-1:0] res_reg [3];
    logic signed [RATE_WIDTH-1:0] w_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            spsr_reg <= qmul(pitch.s, roll.s);
            spcr_reg <= qmul(pitch.s, roll.c);
            cycp_reg <= qmul(yaw.c, pitch.c);
            sycp_reg <= qmul(yaw.s, pitch.c);
            cpsr_reg <= qmul(pitch.c, roll.s);
            cpcr_reg <= qmul(pitch.c, roll.c);
            sycr_reg <= qmul(yaw.s, roll.c);
            sysr_reg <= qmul(yaw.s, roll.s);
            cycr_reg <= qmul(yaw.c, roll.c);
            cysr_reg <= qmul(yaw.c, roll.s);
            cy_a_reg <= yaw.c;
            sy_a_reg <= yaw.s;
            sp_a_reg <= pitch.s;
            w_reg[0] <= '{wx, wy, wz};

            cyspsr_reg <= qmul(cy_a_reg, spsr_reg);
            cyspcr_reg <= qmul(cy_a_reg, spcr_reg);
            syspsr_reg <= qmul(sy_a_reg, spsr_reg);
            syspcr_reg <= qmul(sy_a_reg, spcr_reg);
            sycr_b_reg <= sycr_reg;
            sysr_b_reg <= sysr_reg;
            cycr_b_reg <= cycr_reg;
            cysr_b_reg <= cysr_reg;
            cycp_b_reg <= cycp_reg;
            sycp_b_reg <= sycp_reg;
            cpsr_b_reg <= cpsr_reg;
            cpcr_b_reg <= cpcr_reg;
            sp_b_reg   <= sp_a_reg;
            w_reg[1]   <= w_reg[0];

            m_reg[0][0] <= RE'(cycp_b_reg);
            m_reg[0][1] <= RE'(cyspsr_reg) - RE'(sycr_b_reg);
            m_reg[0][2] <= RE'(cyspcr_reg) + RE'(sysr_b_reg);
            m_reg[1][0] <= RE'(sycp_b_reg);
            m_reg[1][1] <= RE'(syspsr_reg) + RE'(cycr_b_reg);
            m_reg[1][2] <= RE'(syspcr_reg) - RE'(cysr_b_reg);
            m_reg[2][0] <= -RE'(sp_b_reg);
            m_reg[2][1] <= RE'(cpsr_b_reg);
            m_reg[2][2] <= RE'(cpcr_b_reg);
            w_reg[2]    <= w_reg[1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        logic          neg;
        logic [SW-1:0] mag;
        logic [SW-1:0] rm;

        for (genvar j = 0; j < 3; j++) begin : g_col
            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg[i][j] <= PW'(m_reg[i][j]) * PW'(w_reg[2][j]);
                end
            end
        end

        // Round the exact Q30 sum once, by magnitude, then clamp.
        assign neg = sum_reg[i][SW-1];
        assign mag = neg ? SW'(-sum_reg[i]) : SW'(sum_reg[i]);
        assign rm  = (mag + RND) >> FRAC;

        always_ff @(posedge aclk) begin
            if (en) begin
                sum_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
                if (!neg && rm > POS_LIM) begin
                    res_reg[i] <= RATE_WIDTH'(POS_LIM);
                end else if (neg && rm > NEG_LIM) begin
                    res_reg[i] <= RATE_WIDTH'(NEG_LIM);
                end else begin
                    res_reg[i] <= neg ? RATE_WIDTH'(-rm) : RATE_WIDTH'(rm);
                end
            end
        end
    end

    assign world_x = res_reg[0];
    assign world_y = res_reg[1];
    assign world_z = res_reg[2];

endmodule

// ===== design/euler_body_to_world_rate_rotate.sv =====
// Top level of the ZYX Euler body-to-world angular rate rotator: stream handshake,
// valid pipeline and rate delay line. Depends on ebwr_pkg, ebwr_reduce, ebwr_sincos, ebwr_rotate.
//
// Usage:
//   The s_ channel carries one word per sample: roll, pitch and yaw angles
//   (signed, 2^-13 rad) and the body rates x, y, z (signed, 2^-16 rad/s).
//   The m_ channel returns one word per sample with the world-frame rates,
//   rounded and saturated to the rate range. Words leave in arrival order.
//   From acceptance to m_tvalid a word passes ANGLE_WIDTH - 8 stages of angle
//   reduction (one quotient bit of the pi/2 split per division stage), 16
//   stages of sine/cosine series and quadrant selection, and 6 stages of
//   matrix build and matrix-vector product.
//   Throughput is one word per cycle unless the output stalls; every stage is fully pipelined.
//   When the receiver holds m_tready low while a result is waiting, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated, and an
//   empty output register keeps s_tready high regardless of m_tready.
//   Reset (aresetn low, synchronous) empties the pipeline; the block keeps no
//   other state.
`timescale 1ns / 1ps

module euler_body_to_world_rate_rotate #(
    parameter int ANGLE_WIDTH = 16,
    parameter int RATE_WIDTH  = 24,
    localparam int IN_W  = ((3 * ANGLE_WIDTH + 3 * RATE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * RATE_WIDTH + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // roll_angle, pitch_angle, yaw_angle, body_rate_x, body_rate_y, body_rate_z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // world_rate_x, world_rate_y, world_rate_z
    output logic [OUT_W-1:0] m_tdata
);
    import ebwr_pkg::*;

    localparam int LAT = ANGLE_WIDTH + 14;
    localparam int DLY = ANGLE_WIDTH + 8;
    localparam int AW3 = 3 * ANGLE_WIDTH;
    localparam int RW3 = 3 * RATE_WIDTH;

    logic                         en;
    logic [LAT-1:0]               valid_reg;
    logic signed [RATE_WIDTH-1:0] rate_reg [DLY][3];
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    q30_t                         red_r [3];
    logic [1:0]                   red_q [3];
    trig_t                        trig [3];
    logic signed [RATE_WIDTH-1:0] wx_out, wy_out, wz_out;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rate_reg[0][0] <= s_tdata[AW3 +: RATE_WIDTH];
            rate_reg[0][1] <= s_tdata[AW3 + RATE_WIDTH +: RATE_WIDTH];
            rate_reg[0][2] <= s_tdata[AW3 + 2 * RATE_WIDTH +: RATE_WIDTH];
        end
    end

    for (genvar i = 1; i < DLY; i++) begin : g_rate_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                rate_reg[i] <= rate_reg[i-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
        assign ang[a] = s_tdata[a * ANGLE_WIDTH +: ANGLE_WIDTH];

        ebwr_reduce #(
            .ANGLE_WIDTH(ANGLE_WIDTH)
        ) u_reduce (
            .aclk (aclk),
            .en   (en),
            .angle(ang[a]),
            .r    (red_r[a]),
            .quad (red_q[a])
        );

        ebwr_sincos u_sincos (
            .aclk(aclk),
            .en  (en),
            .r   (red_r[a]),
            .quad(red_q[a]),
            .trig(trig[a])
        );
    end

    ebwr_rotate #(
        .RATE_WIDTH(RATE_WIDTH)
    ) u_rotate (
        .aclk   (aclk),
        .en     (en),
        .roll   (trig[0]),
        .pitch  (trig[1]),
        .yaw    (trig[2]),
        .wx     (rate_reg[DLY-1][0]),
        .wy     (rate_reg[DLY-1][1]),
        .wz     (rate_reg[DLY-1][2]),
        .world_x(wx_out),
        .world_y(wy_out),
        .world_z(wz_out)
    );

    assign m_tdata = OUT_W'({wz_out, wy_out, wx_out});

    // Reset must empty the pipeline by the next cycle.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // While the pipeline is frozen no valid bit may move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(valid_reg))
        else $error("valid pipeline moved during stall");

    // An accepted word must occupy the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted word lost at pipeline entry");

    // A word in the stage before the output must appear as a result when the pipeline moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[LAT-2]) |=> m_tvalid)
        else $error("result dropped at output stage");

endmodule
